### design/afr_pkg.sv
package afr_pkg;

  localparam int unsigned PayloadDepth = 32;
  localparam int unsigned AddrW = $clog2(PayloadDepth);
  localparam int unsigned CntW = $clog2(PayloadDepth + 1);

  localparam logic [7:0] ChOpen = 8'h5B;
  localparam logic [7:0] ChClose = 8'h5D;
  localparam logic [7:0] ChVersion = 8'h30;
  localparam logic [7:0] TargetBroadcast = 8'hFF;

  localparam logic [3:0] BoardIdReset = 4'd0;
  localparam logic [15:0] FrameTimeoutReset = 16'd400;

  localparam logic RegBoardId = 1'b0;
  localparam logic RegFrameTimeout = 1'b1;

  localparam logic KindByte = 1'b0;
  localparam logic KindTick = 1'b1;

  typedef enum logic [2:0] {
    PhIdle,
    PhHeader,
    PhVersion,
    PhIdHi,
    PhCollect
  } phase_e;

  typedef enum logic [1:0] {
    RpIdle,
    RpRead,
    RpSend,
    RpMark
  } replay_e;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] length;
  } replay_req_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] addr;
  } mem_rd_t;

  // bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end
    return v;
  endfunction

endpackage

### design/afr_payload_mem.sv
module afr_payload_mem
  import afr_pkg::*;
(
  input  logic       clk_i,
  input  mem_wr_t    wr_i,
  input  mem_rd_t    rd_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [PayloadDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/afr_parser.sv
module afr_parser
  import afr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beat_i,
  input  logic        kind_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [3:0]  board_id_i,
  input  logic [15:0] frame_timeout_i,
  output mem_wr_t     wr_o,
  output replay_req_t req_o
);

  phase_e phase_q, phase_d, cur_phase;
  logic [7:0] target_q, target_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] stamp_q, stamp_d;
  logic byte_beat;
  logic stale;
  logic [15:0] age;
  logic [4:0] hex;
  logic [7:0] id_full;
  logic room;

  assign byte_beat = beat_i && (kind_i == KindByte);
  assign age = tick_q - stamp_q;
  assign stale = (phase_q != PhIdle) && (age > frame_timeout_i);
  assign hex = hex_value(rx_byte_i);
  assign id_full = target_q | {4'b0, hex[3:0]};
  assign room = fill_q < CntW'(PayloadDepth);

  always_comb begin
    cur_phase = phase_q;
    if (rx_byte_i == ChOpen || stale) begin
      cur_phase = PhIdle;
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    if (byte_beat) begin
      unique case (cur_phase)
        PhIdle: begin
          phase_d = (rx_byte_i == ChOpen) ? PhHeader : PhIdle;
        end
        PhHeader: begin
          phase_d = (rx_byte_i == ChVersion) ? PhVersion : PhIdle;
        end
        PhVersion: begin
          phase_d = hex[4] ? PhIdle : PhIdHi;
        end
        PhIdHi: begin
          phase_d = (!hex[4] && id_full == {4'b0, board_id_i}) ? PhCollect : PhIdle;
        end
        PhCollect: begin
          phase_d = (rx_byte_i == ChClose || !room) ? PhIdle : PhCollect;
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    target_d = target_q;
    fill_d = fill_q;
    tick_d = tick_q;
    stamp_d = stamp_q;
    wr_o = '0;
    wr_o.addr = AddrW'(fill_q);
    wr_o.data = rx_byte_i;
    req_o.start = 1'b0;
    req_o.length = fill_q;
    if (beat_i && kind_i == KindTick) begin
      tick_d = tick_q + 16'd1;
    end
    if (byte_beat) begin
      unique case (cur_phase)
        PhIdle: begin
          if (rx_byte_i == ChOpen) begin
            target_d = TargetBroadcast;
            stamp_d = tick_q;
          end
        end
        PhVersion: begin
          if (!hex[4]) begin
            target_d = {hex[3:0], 4'b0};
          end
        end
        PhIdHi: begin
          if (!hex[4]) begin
            target_d = id_full;
            if (id_full == {4'b0, board_id_i}) begin
              fill_d = '0;
            end
          end
        end
        PhCollect: begin
          if (rx_byte_i == ChClose) begin
            req_o.start = 1'b1;
          end else if (room) begin
            wr_o.we = 1'b1;
            fill_d = fill_q + CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      target_q <= TargetBroadcast;
      fill_q <= '0;
      tick_q <= '0;
      stamp_q <= '0;
    end else begin
      phase_q <= phase_d;
      target_q <= target_d;
      fill_q <= fill_d;
      tick_q <= tick_d;
      stamp_q <= stamp_d;
    end
  end

endmodule

### design/afr_replay.sv
module afr_replay
  import afr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  replay_req_t req_i,
  output mem_rd_t     rd_o,
  input  logic [7:0]  rdata_i,
  output logic        busy_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  payload_byte_o,
  output logic [4:0]  byte_index_o,
  output logic [5:0]  frame_length_o,
  output logic        is_last_o
);

  replay_e state_q, state_d;
  logic [CntW-1:0] len_q, len_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] idx_next;

  assign idx_next = idx_q + CntW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    len_d = len_q;
    idx_d = idx_q;
    unique case (state_q)
      RpIdle: begin
        if (req_i.start) begin
          len_d = req_i.length;
          idx_d = '0;
          state_d = (req_i.length == '0) ? RpMark : RpRead;
        end
      end
      RpRead: begin
        state_d = RpSend;
      end
      RpSend: begin
        if (ready_i) begin
          idx_d = idx_next;
          state_d = (idx_next == len_q) ? RpMark : RpRead;
        end
      end
      RpMark: begin
        if (ready_i) begin
          state_d = RpIdle;
        end
      end
      default: begin
        state_d = RpIdle;
      end
    endcase
  end

  // outputs
  always_comb begin
    rd_o.re = 1'b0;
    rd_o.addr = AddrW'(idx_q);
    valid_o = 1'b0;
    payload_byte_o = '0;
    byte_index_o = '0;
    frame_length_o = '0;
    is_last_o = 1'b0;
    unique case (state_q)
      RpRead: begin
        rd_o.re = 1'b1;
      end
      RpSend: begin
        valid_o = 1'b1;
        payload_byte_o = rdata_i;
        byte_index_o = 5'(idx_q);
      end
      RpMark: begin
        valid_o = 1'b1;
        frame_length_o = 6'(len_q);
        is_last_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy_o = (state_q != RpIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RpIdle;
      len_q <= '0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      len_q <= len_d;
      idx_q <= idx_d;
    end
  end

endmodule

### design/addressed_frame_receiver_unit.sv
// channel   dir  signals                          contents
// s_axis    in   tvalid tready tdata[7:0] tuser   rx_byte; tuser = kind (1 = tick)
// m_axis    out  tvalid tready tdata[23:0] tlast  payload_byte, byte_index, frame_length
// apb       in   psel penable pwrite paddr[2:0]   board_id at 0, frame_timeout at 4
//
// an input beat is taken whenever no frame is being replayed
// a closing bracket starts replay: each payload beat is a payload memory read,
// then present (held through any output stall), and after the last one the end marker
// s_axis_tready_o is low for the whole replay
// reset clears control state only; the payload memory is not cleared
module addressed_frame_receiver_unit
  import afr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  input  logic        s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // payload_byte, byte_index, frame_length, zero fill
  output logic        m_axis_tlast_o,   // is_last
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [3:0] board_id_q;
  logic [15:0] frame_timeout_q;
  logic cfg_wr;
  logic beat;
  logic busy;
  mem_wr_t mem_wr;
  mem_rd_t mem_rd;
  logic [7:0] mem_rdata;
  replay_req_t req;
  logic [7:0] payload_byte;
  logic [4:0] byte_index;
  logic [5:0] frame_length;

  assign pready_o = 1'b1;
  assign cfg_wr = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_id_q <= BoardIdReset;
      frame_timeout_q <= FrameTimeoutReset;
    end else if (cfg_wr) begin
      unique case (paddr_i[2])
        RegBoardId: board_id_q <= pwdata_i[3:0];
        RegFrameTimeout: frame_timeout_q <= pwdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      RegBoardId: prdata_o = {28'b0, board_id_q};
      RegFrameTimeout: prdata_o = {16'b0, frame_timeout_q};
      default: prdata_o = '0;
    endcase
  end

  assign s_axis_tready_o = !busy;
  assign beat = s_axis_tvalid_i && !busy;

  afr_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .kind_i         (s_axis_tuser_i),
    .rx_byte_i      (s_axis_tdata_i),
    .board_id_i     (board_id_q),
    .frame_timeout_i(frame_timeout_q),
    .wr_o           (mem_wr),
    .req_o          (req)
  );

  afr_payload_mem u_mem (
    .clk_i  (clk_i),
    .wr_i   (mem_wr),
    .rd_i   (mem_rd),
    .rdata_o(mem_rdata)
  );

  afr_replay u_replay (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .rd_o          (mem_rd),
    .rdata_i       (mem_rdata),
    .busy_o        (busy),
    .valid_o       (m_axis_tvalid_o),
    .ready_i       (m_axis_tready_i),
    .payload_byte_o(payload_byte),
    .byte_index_o  (byte_index),
    .frame_length_o(frame_length),
    .is_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'b0, frame_length, byte_index, payload_byte};

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import afr_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles = 400;
  localparam logic [7:0] LowerA = 8'h61;
  localparam logic [7:0] UpperA = 8'h41;

  class frame_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic [4:0] idx;
      logic [5:0] len;
      logic       last;
    } beat_t;

    logic [3:0]  board_id;
    logic [15:0] timeout_ticks;
    phase_e      phase;
    logic [7:0]  target;
    logic [5:0]  fill;
    logic [15:0] ticks;
    logic [15:0] stamp;
    logic [7:0]  store[PayloadDepth];
    beat_t       pending[$];
    int          errors;

    function new();
      board_id = BoardIdReset;
      timeout_ticks = FrameTimeoutReset;
      phase = PhIdle;
      target = TargetBroadcast;
      fill = '0;
      ticks = '0;
      stamp = '0;
      errors = 0;
    endfunction

    // bit 4 set for a non-hex character
    function logic [4:0] hex_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
      if (c >= LowerA && c <= LowerA + 8'd5) return 5'(c - LowerA + 8'd10);
      if (c >= UpperA && c <= UpperA + 8'd5) return 5'(c - UpperA + 8'd10);
      return 5'h10;
    endfunction

    function void set_reg(logic sel, logic [31:0] val);
      if (sel == RegBoardId) begin
        board_id = val[3:0];
      end else begin
        timeout_ticks = val[15:0];
      end
    endfunction

    function void note_input(logic kind, logic [7:0] c);
      logic [4:0] d;
      beat_t      e;
      int         k;
      if (kind == KindTick) begin
        ticks = ticks + 16'd1;
        return;
      end
      if (c == ChOpen) phase = PhIdle;
      if (phase != PhIdle && 16'(ticks - stamp) > timeout_ticks) phase = PhIdle;
      d = hex_of(c);
      case (phase)
        PhIdle: begin
          if (c == ChOpen) begin
            phase = PhHeader;
            target = TargetBroadcast;
            stamp = ticks;
          end
        end
        PhHeader: begin
          phase = (c == ChVersion) ? PhVersion : PhIdle;
        end
        PhVersion: begin
          if (!d[4]) begin
            target = {d[3:0], 4'h0};
            phase = PhIdHi;
          end else begin
            phase = PhIdle;
          end
        end
        PhIdHi: begin
          if (!d[4]) begin
            target = target | {4'h0, d[3:0]};
            if (target == {4'h0, board_id}) begin
              fill = '0;
              phase = PhCollect;
            end else begin
              phase = PhIdle;
            end
          end else begin
            phase = PhIdle;
          end
        end
        PhCollect: begin
          if (c == ChClose) begin
            for (k = 0; k < int'(fill); k++) begin
              e.data = store[k];
              e.idx = 5'(k);
              e.len = '0;
              e.last = 1'b0;
              pending.push_back(e);
            end
            e.data = '0;
            e.idx = '0;
            e.len = fill;
            e.last = 1'b1;
            pending.push_back(e);
            phase = PhIdle;
          end else if (fill < PayloadDepth) begin
            store[fill] = c;
            fill = fill + 6'd1;
          end else begin
            phase = PhIdle;
          end
        end
        default: phase = PhIdle;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [23:0] d, logic last);
      beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat data %h last %b", d, last));
        return;
      end
      e = pending.pop_front();
      if (d[7:0] !== e.data)
        report($sformatf("payload_byte %h, want %h", d[7:0], e.data));
      if (d[12:8] !== e.idx)
        report($sformatf("byte_index %0d, want %0d", d[12:8], e.idx));
      if (d[18:13] !== e.len)
        report($sformatf("frame_length %0d, want %0d", d[18:13], e.len));
      if (last !== e.last)
        report($sformatf("is_last %b, want %b", last, e.last));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;   // rx_byte
  logic        s_user;   // kind
  logic        m_valid;
  logic        m_ready;
  logic [23:0] m_data;   // payload_byte, byte_index, frame_length, zero fill
  logic        m_last;   // is_last
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb;
  int  send_pct;
  int  recv_pct;
  bit  hold_req;
  int  items_sent;
  longint cycles;

  addressed_frame_receiver_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_result(m_data, m_last);
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // called and returning at a falling edge
  task automatic send_beat(logic kind, logic [7:0] c);
    while ($urandom_range(99) < send_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= kind;
    s_data <= c;
    do @(posedge clk_i); while (!(s_valid && s_ready));
    sb.note_input(kind, c);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] c);
    send_beat(KindByte, c);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_beat(KindTick, 8'($urandom_range(255)));
  endtask

  task automatic maybe_ticks();
    int r;
    r = $urandom_range(99);
    if (r < 8) send_ticks(1);
    else if (r < 10) send_ticks($urandom_range(40, 5));
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return ChVersion + 8'(v);
    return ($urandom_range(1) ? LowerA : UpperA) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    logic [4:0] h;
    do begin
      c = 8'($urandom_range(255));
      h = sb.hex_of(c);
    end while (!h[4]);
    return c;
  endfunction

  task automatic own_frame();
    int r;
    int n;
    r = $urandom_range(99);
    n = (r < 70) ? $urandom_range(6) : (r < 92) ? $urandom_range(32, 7) : $urandom_range(34, 33);
    send_byte(ChOpen);
    maybe_ticks();
    send_byte(ChVersion);
    maybe_ticks();
    send_byte(hex_char(4'h0));
    send_byte(hex_char(sb.board_id));
    repeat (n) begin
      maybe_ticks();
      send_byte(8'($urandom_range(255)));
    end
    if ($urandom_range(9) != 0) send_byte(ChClose);
  endtask

  task automatic broken_frame();
    logic [3:0] hi;
    logic [3:0] lo;
    send_byte(ChOpen);
    case ($urandom_range(3))
      0: send_byte(8'($urandom_range(255)) == ChVersion ? ChClose : 8'($urandom_range(255)));
      1: begin
        send_byte(ChVersion);
        send_byte(non_hex());
      end
      2: begin
        send_byte(ChVersion);
        send_byte(hex_char(4'($urandom_range(15))));
        send_byte(non_hex());
      end
      default: begin
        hi = 4'($urandom_range(15));
        lo = 4'($urandom_range(15));
        if ({hi, lo} == {4'h0, sb.board_id}) lo = lo ^ 4'h1;
        send_byte(ChVersion);
        send_byte(hex_char(hi));
        send_byte(hex_char(lo));
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
        send_byte(ChClose);
      end
    endcase
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic sel, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(sel, val);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int seg;
    int first;
    logic [3:0]  id;
    logic [15:0] tmo;
    int r;
    sb = new();
    rst_ni = 1'b0;
    s_valid = 1'b0;
    s_data = '0;
    s_user = KindByte;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    items_sent = 0;
    cycles = 0;
    send_pct = 37;
    recv_pct = 49;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extreme payload values, empty frame, bad version, bad digit,
    // wrong address, restart mid-header, ticks and stray closing bracket
    send_byte(ChOpen); send_byte(ChVersion); send_byte(ChVersion); send_byte(ChVersion);
    send_byte(8'h00); send_byte(8'hFF); send_byte(ChClose);
    send_byte(ChOpen); send_byte(ChVersion); send_byte(ChVersion); send_byte(ChVersion);
    send_byte(ChClose);
    send_byte(ChOpen); send_byte(8'h31);
    send_byte(ChOpen); send_byte(ChVersion); send_byte(8'h67);
    send_byte(ChOpen); send_byte(ChVersion); send_byte(ChVersion); send_byte(8'h35);
    send_byte(ChClose);
    send_byte(ChOpen); send_byte(ChVersion); send_byte(ChOpen); send_byte(ChVersion);
    send_ticks(1);
    send_byte(ChVersion); send_byte(ChVersion); send_byte(8'h5A); send_byte(ChClose);

    for (seg = 0; seg < 9; seg++) begin
      drain();
      send_pct = (seg < 3) ? 37 : (seg < 6) ? 49 : 0;
      recv_pct = (seg < 3) ? 49 : (seg < 6) ? 37 : 0;
      id = 4'($urandom_range(15));
      case (seg)
        0: begin id = 4'd0;  tmo = 16'hFFFF; end
        1: begin id = 4'd15; tmo = 16'd0; end
        2: tmo = 16'($urandom_range(40));
        3: begin id = 4'd15; tmo = 16'hFFFF; end
        4: begin id = 4'd0;  tmo = 16'd0; end
        5: tmo = FrameTimeoutReset;
        6: tmo = 16'($urandom_range(60));
        7: begin id = 4'd15; tmo = 16'($urandom_range(20)); end
        default: tmo = 16'd20;
      endcase
      write_reg(RegBoardId, ($urandom() & 32'hFFFF_FFF0) | 32'(id));
      write_reg(RegFrameTimeout, ($urandom() & 32'hFFFF_0000) | 32'(tmo));
      if (seg == 6) hold_req = 1'b1;
      first = items_sent;
      while (items_sent - first < 40) begin
        r = $urandom_range(99);
        if (r < 70) begin
          own_frame();
        end else if (r < 85) begin
          broken_frame();
        end else begin
          repeat ($urandom_range(5, 1)) send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
      end
    end

    s_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
